[rtl/core/tga_rle_decoder_core_assert.svh]
// Assertion macros for the TGA run-length decoder core
`ifndef TGA_RLE_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define TGARLE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset
`define TGARLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGARLE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define TGARLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/core/tgarle_pkg.sv]
// Shared constants, types and helpers of the TGA run-length decoder
`default_nettype none

package tgarle_pkg;

  localparam int MAX_BYTES_PER_PIXEL = 4;
  localparam int WORD_BYTES          = 8;
  localparam int MAX_RESULTS         = 64;
  localparam int MAX_RUN_PIXELS      = 128;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = WORD_BYTES * BYTE_W;
  localparam int PIXEL_W    = MAX_BYTES_PER_PIXEL * BYTE_W;
  localparam int BPP_W      = 3;
  localparam int SIZE_W     = 28;
  localparam int FILL_W     = $clog2(WORD_BYTES + 1);
  localparam int CNT_W      = 4;
  localparam int LEFT_W     = 8;
  localparam int IDX_W      = $clog2(MAX_BYTES_PER_PIXEL);
  localparam int RUN_W      = $clog2(MAX_RUN_PIXELS * MAX_BYTES_PER_PIXEL + 1);
  localparam int PROD_W     = LEFT_W + BPP_W;
  localparam int RES_W      = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP         = 1'd0,
    CFG_IMAGE_BYTES = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_LIT    = 2'd2
  } phase_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_BUSY = 1'b1
  } back_st_e;

  typedef enum logic [1:0] {
    CMD_NOP = 2'd0,
    CMD_LIT = 2'd1,
    CMD_RUN = 2'd2
  } cmd_kind_e;

  // One command per accepted item
  typedef struct packed {
    cmd_kind_e          kind;
    logic [PIXEL_W-1:0] pixel;
    logic [BPP_W-1:0]   bpp;
    logic [RUN_W-1:0]   nbytes;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Out-of-range depth: zero acts as one, above the maximum acts as the maximum
  function automatic logic [BPP_W-1:0] clamp_depth(input logic [BPP_W-1:0] raw);
    logic [BPP_W-1:0] res;
    if (raw == '0) begin
      res = BPP_W'(1);
    end else if (raw > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
      res = BPP_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tgarle_if.sv]
// Channel interfaces: compressed byte input, decoded word output, config writes
`default_nettype none

interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tgarle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic [3:0]  out_count;
  logic        last_word;
  modport source (output valid, output out_word, output out_count, output last_word,
                  input ready);
  modport sink   (input valid, input out_word, input out_count, input last_word,
                  output ready);
endinterface

interface tgarle_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [27:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/tgarle_front.sv]
// Packet parser: classifies each byte and issues one command per item
`default_nettype none

module tgarle_front import tgarle_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  tgarle_in_if.sink      in_ch,
  tgarle_cfg_if.sink     cfg_ch,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output cmd_t           cmd
);

  logic [BPP_W-1:0]   bpp_cfg_r;
  logic [SIZE_W-1:0]  img_bytes_r;
  phase_e             phase_r, phase_nxt;
  logic [LEFT_W-1:0]  pix_left_r, pix_left_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PIXEL_W-1:0] pixbuf_r, pixbuf_nxt;
  logic [SIZE_W-1:0]  done_cnt_r, done_cnt_nxt;

  logic               accept;
  logic [BPP_W-1:0]   bpp;
  logic               pix_end;
  logic [PIXEL_W-1:0] pb;
  logic [PROD_W-1:0]  run_prod;
  logic [SIZE_W-1:0]  rem;
  logic               run_done;
  logic               lit_done;
  logic [LEFT_W-1:0]  pl_dec;

  assign in_ch.ready  = cmd_ready;
  assign cmd_valid    = in_ch.valid;
  assign accept       = in_ch.valid && cmd_ready;
  assign cfg_ch.ready = 1'b1;

  assign bpp      = clamp_depth(bpp_cfg_r);
  assign pix_end  = ({1'b0, idx_r} + 3'd1) >= bpp;
  assign pb       = pixbuf_r | (PIXEL_W'(in_ch.in_byte) << {idx_r, 3'b000});
  assign run_prod = pix_left_r * bpp;
  // Bytes still due in this image; zero stands for a full wrap
  assign rem      = img_bytes_r - done_cnt_r;
  assign run_done = (rem != '0) && (rem <= SIZE_W'(run_prod));
  assign lit_done = (rem == SIZE_W'(1));
  assign pl_dec   = (pix_left_r != '0) ? pix_left_r - LEFT_W'(1) : pix_left_r;

  // Command toward the back end
  always_comb begin
    cmd.kind   = CMD_NOP;
    cmd.pixel  = pb;
    cmd.bpp    = bpp;
    cmd.nbytes = RUN_W'(1);
    cmd.last   = 1'b0;
    case (phase_r)
      PH_RUN: begin
        if (pix_end) begin
          cmd.kind   = CMD_RUN;
          cmd.nbytes = run_done ? RUN_W'(rem) : RUN_W'(run_prod);
          cmd.last   = run_done;
        end
      end
      PH_LIT: begin
        cmd.kind  = CMD_LIT;
        cmd.pixel = PIXEL_W'(in_ch.in_byte);
        cmd.last  = lit_done;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  // Next parser state
  always_comb begin
    phase_nxt    = phase_r;
    pix_left_nxt = pix_left_r;
    idx_nxt      = idx_r;
    pixbuf_nxt   = pixbuf_r;
    done_cnt_nxt = done_cnt_r;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          pix_left_nxt = {1'b0, in_ch.in_byte[6:0]} + LEFT_W'(1);
          idx_nxt      = '0;
          pixbuf_nxt   = '0;
          phase_nxt    = in_ch.in_byte[7] ? PH_RUN : PH_LIT;
        end
        PH_RUN: begin
          if (pix_end) begin
            phase_nxt    = PH_HEADER;
            pix_left_nxt = '0;
            idx_nxt      = '0;
            pixbuf_nxt   = '0;
            done_cnt_nxt = run_done ? '0 : done_cnt_r + SIZE_W'(run_prod);
          end else begin
            idx_nxt    = idx_r + IDX_W'(1);
            pixbuf_nxt = pb;
          end
        end
        PH_LIT: begin
          if (lit_done) begin
            // Image complete: rearm, remaining packet bytes start a new image
            phase_nxt    = PH_HEADER;
            pix_left_nxt = '0;
            idx_nxt      = '0;
            pixbuf_nxt   = '0;
            done_cnt_nxt = '0;
          end else begin
            done_cnt_nxt = done_cnt_r + SIZE_W'(1);
            if (pix_end) begin
              idx_nxt      = '0;
              pix_left_nxt = pl_dec;
              if (pl_dec == '0) begin
                phase_nxt = PH_HEADER;
              end
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pix_left_r <= '0;
      idx_r      <= '0;
      pixbuf_r   <= '0;
      done_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pix_left_r <= pix_left_nxt;
      idx_r      <= idx_nxt;
      pixbuf_r   <= pixbuf_nxt;
      done_cnt_r <= done_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_cfg_r   <= BPP_W'(1);
      img_bytes_r <= SIZE_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_e'(cfg_ch.index))
        CFG_BPP:         bpp_cfg_r   <= cfg_ch.data[BPP_W-1:0];
        CFG_IMAGE_BYTES: img_bytes_r <= cfg_ch.data[SIZE_W-1:0];
        default: begin
          bpp_cfg_r <= bpp_cfg_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/tgarle_queue.sv]
// Short command queue between parser and word packer
`default_nettype none

module tgarle_queue import tgarle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output cmd_t      pop_cmd,
  output q_status_t status
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign push_ready   = !status.full;
  assign pop_valid    = !status.empty;
  assign pop_cmd      = mem_r[rd_ptr_r];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/tgarle_back.sv]
// Word packer: expands commands byte by byte into 64-bit result words
`default_nettype none

module tgarle_back import tgarle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd,
  tgarle_out_if.source out_ch
);

  back_st_e           st_r, st_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [RUN_W-1:0]   left_r, left_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [RES_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic               hold_r, hold_nxt;
  logic [WORD_W-1:0]  wbuf_r, wbuf_nxt;
  logic [FILL_W-1:0]  wfill_r, wfill_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic               slot_free;
  logic [BYTE_W-1:0]  byte_sel;
  logic [FILL_W-1:0]  fill_inc;
  logic [WORD_W-1:0]  wbuf_add;
  logic               final_b;
  logic               need_emit;
  logic               hold_now;
  logic               step_ok;
  logic               flush_go;
  logic               pop;
  logic               k_last;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign byte_sel  = BYTE_W'(cmd_r.pixel >> {k_r, 3'b000});
  assign fill_inc  = wfill_r + FILL_W'(1);
  assign wbuf_add  = wbuf_r | (WORD_W'(byte_sel) << {wfill_r[FILL_W-2:0], 3'b000});
  assign final_b   = (left_r == RUN_W'(1)) && cmd_r.last;
  assign need_emit = (fill_inc == FILL_W'(WORD_BYTES)) || final_b;
  // A final word beyond the per-item result limit waits for the next item
  assign hold_now  = final_b && (res_cnt_r == RES_W'(MAX_RESULTS));
  assign step_ok   = !need_emit || hold_now || slot_free;
  assign flush_go  = (st_r == BK_IDLE) && hold_r && cmd_valid && slot_free;
  assign pop       = (st_r == BK_IDLE) && !hold_r && cmd_valid;
  assign cmd_ready = pop;
  assign k_last    = ({1'b0, k_r} + 3'd1) >= cmd_r.bpp;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_word  = out_word_r;
  assign out_ch.out_count = out_count_r;
  assign out_ch.last_word = out_last_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (pop && (cmd.kind != CMD_NOP)) begin
          st_nxt = BK_BUSY;
        end
      end
      BK_BUSY: begin
        if (step_ok && (left_r == RUN_W'(1))) begin
          st_nxt = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    left_nxt      = left_r;
    k_nxt         = k_r;
    res_cnt_nxt   = res_cnt_r;
    hold_nxt      = hold_r;
    wbuf_nxt      = wbuf_r;
    wfill_nxt     = wfill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    case (st_r)
      BK_IDLE: begin
        if (flush_go) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = wbuf_r;
          out_count_nxt = CNT_W'(wfill_r);
          out_last_nxt  = 1'b1;
          wbuf_nxt      = '0;
          wfill_nxt     = '0;
          hold_nxt      = 1'b0;
        end
        if (pop) begin
          cmd_nxt     = cmd;
          left_nxt    = cmd.nbytes;
          k_nxt       = '0;
          res_cnt_nxt = '0;
        end
      end
      BK_BUSY: begin
        if (step_ok) begin
          left_nxt = left_r - RUN_W'(1);
          k_nxt    = k_last ? '0 : k_r + IDX_W'(1);
          if (hold_now) begin
            wbuf_nxt  = wbuf_add;
            wfill_nxt = fill_inc;
            hold_nxt  = 1'b1;
          end else if (need_emit) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = wbuf_add;
            out_count_nxt = CNT_W'(fill_inc);
            out_last_nxt  = final_b;
            wbuf_nxt      = '0;
            wfill_nxt     = '0;
            res_cnt_nxt   = res_cnt_r + RES_W'(1);
          end else begin
            wbuf_nxt  = wbuf_add;
            wfill_nxt = fill_inc;
          end
        end
      end
      default: begin
        hold_nxt = hold_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      hold_r      <= 1'b0;
      wbuf_r      <= '0;
      wfill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      hold_r      <= hold_nxt;
      wbuf_r      <= wbuf_nxt;
      wfill_r     <= wfill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    left_r      <= left_nxt;
    k_r         <= k_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_word_r  <= out_word_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/tga_rle_decoder_core.sv]
// Top level of the TGA run-length decoder: parser, command queue, word packer
//
// Decodes the run-length pixel stream of a TGA image, one compressed byte per
// item, into 64-bit words of eight decoded bytes, first byte lowest. The parser
// takes one byte per cycle while its two-entry command queue has room; header
// bytes and leading bytes of a run pixel need no packing step, and a literal
// byte is packed as a single decoded byte. A run packet is expanded one decoded
// byte per cycle by the packer while its output slot is free, and input stalls
// once the queue fills behind it. The image ends exactly at the configured byte
// count: the rest of a run is dropped and the word holding the last byte goes
// out with last_word set, after which the next byte is read as a fresh packet
// header. When the last word would be the 65th word of one run packet, it is
// held and sent at the next item. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

`include "tga_rle_decoder_core_assert.svh"

module tga_rle_decoder_core import tgarle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  tgarle_in_if.sink    in_ch,
  tgarle_out_if.source out_ch,
  tgarle_cfg_if.sink   cfg_ch
);

  // Parser to queue
  logic      front_valid;
  logic      front_ready;
  cmd_t      front_cmd;

  // Queue to packer
  logic      q_valid;
  logic      q_ready;
  cmd_t      q_cmd;
  q_status_t q_status;

  // Classify bytes, track pixel counts and image progress
  tgarle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decouple the parser from word packing so each side stalls on its own
  tgarle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd),
    .status     (q_status)
  );

  // Expand runs, pack bytes into words, hold the output register
  tgarle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_ch    (out_ch)
  );

  // Only the final word of an image may be short
  `TGARLE_ASSERT_IMPLY(a_short_only_last, clk, rst_n, out_ch.valid && !out_ch.last_word, out_ch.out_count == CNT_W'(WORD_BYTES), "short word without last flag")
  // Input must stall while the queue has no room
  `TGARLE_ASSERT_IMPLY(a_full_stalls_input, clk, rst_n, q_status.full, !in_ch.ready, "input ready while queue full")

endmodule

`default_nettype wire

[dv/tga_rle_decoder_core_tb.sv]
// Self-checking testbench for the TGA run-length decoder core
`default_nettype none

module tga_rle_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgarle_pkg::*;

  localparam int          HALF_PERIOD     = 4;
  localparam int          RESET_CYCLES    = 9;
  localparam int          MAX_GAP         = 17;
  // Once the last predicted word is out, the packer may still be packing the
  // tail of a run (under eight bytes) and up to two queued commands; wait well
  // past that before touching registers.
  localparam int          DRAIN_CYCLES    = 600;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          QUIET_LIMIT     = 4000;
  localparam int          RANDOM_ITEMS    = 150;
  localparam logic [27:0] IMAGE_BYTES_MAX = 28'hFFFFFFF;

  // Decoder phases as the prediction tracks them; HELD means the final word
  // of an image could not go out with the run that finished it.
  typedef enum logic [1:0] {
    DEC_HEADER = 2'd0,
    DEC_RUN    = 2'd1,
    DEC_LIT    = 2'd2,
    DEC_HELD   = 2'd3
  } dec_phase_e;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  nbytes;
    logic              is_last;
  } decoded_word_t;

  logic clk;
  logic rst_n;

  tgarle_in_if  in_ch();
  tgarle_out_if out_ch();
  tgarle_cfg_if cfg_ch();

  tga_rle_decoder_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // ------------------------------------------------------------------------
  // Decoder prediction: register copies, parser state and word packer
  // ------------------------------------------------------------------------
  logic [BPP_W-1:0]   cur_bpp;
  logic [SIZE_W-1:0]  cur_size;
  dec_phase_e         st_phase;
  int                 st_left;
  int                 st_idx;
  logic [PIXEL_W-1:0] st_pixel;
  logic [SIZE_W-1:0]  st_done;
  logic [WORD_W-1:0]  st_word;
  int                 st_fill;
  int                 step_words;

  decoded_word_t pending_words[$];

  int unsigned mismatches;
  int unsigned in_items;
  bit          in_burst;
  bit          rx_burst;
  bit          hold_req;
  bit          rx_hold;

  // Zero acts as one byte, anything above four acts as four
  function automatic int eff_depth(input logic [BPP_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > BPP_W'(MAX_BYTES_PER_PIXEL)) return MAX_BYTES_PER_PIXEL;
    return int'(raw);
  endfunction

  function automatic void rearm_image();
    st_phase = DEC_HEADER;
    st_left  = 0;
    st_idx   = 0;
    st_pixel = '0;
    st_done  = '0;
  endfunction

  function automatic void reset_model();
    cur_bpp  = BPP_W'(1);
    cur_size = SIZE_W'(1);
    rearm_image();
    st_word = '0;
    st_fill = 0;
  endfunction

  function automatic void emit_word(input bit is_last);
    decoded_word_t w;
    w.data    = st_word;
    w.nbytes  = CNT_W'(st_fill);
    w.is_last = is_last;
    pending_words.push_back(w);
    st_word = '0;
    st_fill = 0;
    step_words++;
  endfunction

  // Pack one decoded byte; flag the end of the image
  function automatic void pack_byte(input logic [7:0] b, output bit fin);
    st_word |= WORD_W'(b) << ((st_fill % WORD_BYTES) * 8);
    st_fill++;
    st_done = st_done + SIZE_W'(1);
    fin = (st_done == cur_size);
    if (st_fill >= WORD_BYTES || fin) begin
      if (step_words < MAX_RESULTS) begin
        emit_word(fin);
        if (fin) rearm_image();
      end else if (fin) begin
        // Too many words for one item: hold the last one for the next item
        rearm_image();
        st_phase = DEC_HELD;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    int dep;
    int runs;
    bit fin;
    dep        = eff_depth(cur_bpp);
    step_words = 0;
    fin        = 1'b0;
    if (st_phase == DEC_HELD) begin
      emit_word(1'b1);
      st_phase = DEC_HEADER;
    end
    case (st_phase)
      DEC_HEADER: begin
        st_left  = int'(b[6:0]) + 1;
        st_idx   = 0;
        st_pixel = '0;
        st_phase = b[7] ? DEC_RUN : DEC_LIT;
      end
      DEC_RUN: begin
        st_pixel |= PIXEL_W'(b) << (st_idx * 8);
        if (st_idx + 1 >= dep) begin
          runs     = st_left;
          st_phase = DEC_HEADER;
          st_left  = 0;
          st_idx   = 0;
          for (int p = 0; p < runs && !fin; p++) begin
            for (int k = 0; k < dep && !fin; k++) begin
              pack_byte(st_pixel[k*8 +: 8], fin);
            end
          end
          if (!fin) st_pixel = '0;
        end else begin
          st_idx = (st_idx + 1) % MAX_BYTES_PER_PIXEL;
        end
      end
      DEC_LIT: begin
        pack_byte(b, fin);
        if (!fin) begin
          if (st_idx + 1 >= dep) begin
            st_idx = 0;
            if (st_left > 0) st_left--;
            if (st_left == 0) st_phase = DEC_HEADER;
          end else begin
            st_idx = (st_idx + 1) % MAX_BYTES_PER_PIXEL;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Channel drivers
  // ------------------------------------------------------------------------

  // Offer one compressed byte; valid stays high into the next item when it
  // follows without a gap, so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    // While the receiver is held off, push as hard as possible
    gap = (in_burst || rx_hold) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b);
    in_items++;
  endtask

  // Write both registers back to back, valid held high across the pair
  task automatic program_config(input logic [BPP_W-1:0] bpp, input logic [SIZE_W-1:0] size);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_BPP;
    cfg_ch.data  <= CFG_DATA_W'(bpp);
    do @(posedge clk); while (!cfg_ch.ready);
    cur_bpp = bpp;
    cfg_ch.index <= CFG_IMAGE_BYTES;
    cfg_ch.data  <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_size = size;
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, drain every predicted word, then let the packer go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One packet of random content; now and then a stray byte instead
  task automatic send_packet();
    int dep;
    int cnt;
    int unsigned pick;
    dep  = eff_depth(cur_bpp);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_byte(8'($urandom));
    end else if (pick < 5) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_RUN_PIXELS)
                                          : $urandom_range(1, 8);
      send_byte({1'b1, 7'(cnt - 1)});
      repeat (dep) send_byte(8'($urandom));
    end else begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      send_byte({1'b0, 7'(cnt - 1)});
      repeat (cnt * dep) send_byte(8'($urandom));
    end
  endtask

  // ------------------------------------------------------------------------
  // Receiver: random stalls per word, compare against the oldest prediction
  // ------------------------------------------------------------------------
  initial begin : word_receiver
    int unsigned   stall;
    decoded_word_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0 || rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_words.size() == 0) begin
        $error("unexpected word %h, out_count %0d, last_word %0b",
               out_ch.out_word, out_ch.out_count, out_ch.last_word);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (out_ch.out_word !== want.data) begin
          $error("out_word: expected %h, actual %h", want.data, out_ch.out_word);
          mismatches++;
        end
        if (out_ch.out_count !== want.nbytes) begin
          $error("out_count: expected %0d, actual %0d", want.nbytes, out_ch.out_count);
          mismatches++;
        end
        if (out_ch.last_word !== want.is_last) begin
          $error("last_word: expected %0b, actual %0b", want.is_last, out_ch.last_word);
          mismatches++;
        end
      end
    end
  end

  // Long receiver hold-off, timed here so the sender keeps going meanwhile
  initial begin : rx_hold_timer
    rx_hold = 1'b0;
    forever begin
      wait (hold_req);
      hold_req = 1'b0;
      rx_hold  = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  // Watchdog: end the run once no channel has moved for too long
  logic accepted;
  assign accepted = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                    (cfg_ch.valid && cfg_ch.ready);

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (accepted) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset values: one-byte pixels, one-byte image
  task automatic check_reset_values();
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();
  endtask

  // Longest run with four-byte pixels after a half word: the 65th word is
  // the final one, so it waits for the next item
  task automatic check_result_limit();
    program_config(3'd4, 28'd516);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    settle();
  endtask

  // Release the held word, start a run pixel, then shrink the depth under it
  task automatic check_depth_change();
    send_byte(8'h81);
    send_byte(8'h11);
    send_byte(8'h22);
    settle();
    program_config(3'd2, 28'd6);
    send_byte(8'h33);
    send_byte(8'h00);
    send_byte(8'hC3);
    send_byte(8'h3C);
    settle();
  endtask

  // Out-of-range depths, and a run cut short at the image end
  task automatic check_depth_clamp();
    program_config(3'd0, 28'd3);
    send_byte(8'h02);
    send_byte(8'hAA);
    send_byte(8'hBB);
    send_byte(8'hCC);
    settle();
    program_config(3'd7, 28'd3);
    send_byte(8'h80);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    settle();
  endtask

  // Longest literal packet overrunning a two-byte image
  task automatic check_literal_overshoot();
    program_config(3'd1, 28'd2);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'h02);
    settle();
  endtask

  // Hold the receiver off while long runs and literals keep coming, so the
  // queue fills and the input stalls
  task automatic check_output_stall();
    program_config(3'd1, IMAGE_BYTES_MAX);
    hold_req = 1'b1;
    repeat (3) begin
      send_byte(8'hFF);
      send_byte(8'($urandom));
      send_byte(8'h0F);
      repeat (16) send_byte(8'($urandom));
    end
    settle();
  endtask

  // Random images under changing settings; a new size always lies above the
  // bytes already decoded so the count never has to wrap
  task automatic check_random_images(input int unsigned target);
    int unsigned      start;
    int unsigned      mark;
    int unsigned      phase_len;
    int unsigned      pick;
    logic [BPP_W-1:0] bpp;
    logic [SIZE_W-1:0] size;
    start = in_items;
    while (in_items - start < target) begin
      bpp  = ($urandom_range(0, 7) == 0) ? BPP_W'($urandom_range(0, 7))
                                         : BPP_W'($urandom_range(1, MAX_BYTES_PER_PIXEL));
      pick = $urandom_range(0, 9);
      if (pick == 0) size = IMAGE_BYTES_MAX;
      else if (pick == 1) size = st_done + SIZE_W'(1);
      else if (pick < 4) size = st_done + SIZE_W'($urandom_range(1, 2000));
      else size = st_done + SIZE_W'($urandom_range(1, 120));
      program_config(bpp, size);
      phase_len = $urandom_range(15, 45);
      mark      = in_items;
      while (in_items - mark < phase_len) send_packet();
      settle();
    end
  endtask

  initial begin : main
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_BPP;
    cfg_ch.data   <= '0;
    rst_n         <= 1'b0;
    mismatches = 0;
    in_items   = 0;
    in_burst   = 1'b0;
    rx_burst   = 1'b0;
    hold_req   = 1'b0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    check_reset_values();
    check_result_limit();
    check_depth_change();
    check_depth_clamp();
    check_literal_overshoot();
    check_output_stall();
    check_random_images(RANDOM_ITEMS);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_if.sv
rtl/core/tgarle_front.sv
rtl/core/tgarle_queue.sv
rtl/core/tgarle_back.sv
rtl/core/tga_rle_decoder_core.sv
dv/tga_rle_decoder_core_tb.sv
